// ===== hw/rtl/rbd_pkg.sv =====
`default_nettype none

package rbd_pkg;

    localparam int MAX_WIDTH_DEF  = 256;
    localparam int MAX_HEIGHT_DEF = 256;

    localparam int WORD_BITS = 32;
    localparam int BIT_W     = 5;

    localparam int CFG_W     = 9;
    localparam int CFG_MAX   = (2 ** CFG_W) - 1;
    localparam int CFG_IDX_W = 1;

    localparam int WPR_W  = CFG_W + 1 - BIT_W;
    localparam int LINE_W = CFG_W + WPR_W;
    localparam int SEG_W  = BIT_W + 1;
    localparam int CNT_W  = 7;
    localparam int COORD_W = 8;

    localparam logic [CFG_W-1:0] DIM_RESET = CFG_W'(256);

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_HEIGHT = 1'b1;

    localparam logic [1:0] OP_FILL = 2'd0;
    localparam logic [1:0] OP_RUN  = 2'd1;
    localparam logic [1:0] OP_READ = 2'd2;

endpackage

`default_nettype wire

// ===== hw/rtl/rbd_ram.sv =====
`default_nettype none

module rbd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2048,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    addr,
    input  logic [WIDTH-1:0] wdata,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[addr] <= wdata;
        end
        rdata_reg <= mem_reg[addr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/rle_bitmap_decoder_core.sv =====
// rle_bitmap_decoder_core: 1 bit per pixel frame store filled from run-length codes
//
// input channel (in_valid / in_stall): one beat carries op, fill_color, run_byte,
// read_x and read_y. op fill paints the whole store and homes the cursor, op run
// writes run_byte[6:0] pixels of colour run_byte[7] from the cursor, op read looks
// up one pixel. every beat yields exactly one beat on the output channel
// (out_valid / out_stall) with pixel_color, out_of_range and the cursor.
// configuration (cfg_we, cfg_index, cfg_data) sets width and height; write it idle.
//
// one item is worked at a time through a single-port store with registered read;
// in_stall is high from acceptance until the sequencer is back in idle.
// fill writes every store word (2048 at default size), one word per cycle; run
// reads then writes each touched word (up to 5 words for 127 pixels in a wide
// row, one word per pixel at width 1); read looks up one word unless the pixel
// lies outside the image; an unused op goes straight to the result.
// a finished result sits in the output register, so the next beat is taken while
// the receiver stalls; the sequencer only waits if a second result is ready first.
// reset homes the cursor, sets width and height to 256 and empties the output;
// the pixel store is not cleared and holds nothing defined until a fill.
`default_nettype none

module rle_bitmap_decoder_core #(
    parameter int MAX_WIDTH  = rbd_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = rbd_pkg::MAX_HEIGHT_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,

    input  logic                            cfg_we,
    input  logic [rbd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [rbd_pkg::CFG_W-1:0]       cfg_data,

    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [1:0]                      op,
    input  logic                            fill_color,
    input  logic [7:0]                      run_byte,
    input  logic [rbd_pkg::COORD_W-1:0]     read_x,
    input  logic [rbd_pkg::COORD_W-1:0]     read_y,

    output logic                            out_valid,
    input  logic                            out_stall,
    output logic                            pixel_color,
    output logic                            out_of_range,
    output logic [rbd_pkg::COORD_W-1:0]     cursor_col,
    output logic [rbd_pkg::CFG_W-1:0]       cursor_row
);

    localparam int CFG_W   = rbd_pkg::CFG_W;
    localparam int BIT_W   = rbd_pkg::BIT_W;
    localparam int WPR_W   = rbd_pkg::WPR_W;
    localparam int LINE_W  = rbd_pkg::LINE_W;
    localparam int SEG_W   = rbd_pkg::SEG_W;
    localparam int CNT_W   = rbd_pkg::CNT_W;
    localparam int COORD_W = rbd_pkg::COORD_W;
    localparam int WORD_BITS = rbd_pkg::WORD_BITS;

    localparam int WPR_MAX     = (MAX_WIDTH + WORD_BITS - 1) / WORD_BITS;
    localparam int STORE_WORDS = MAX_HEIGHT * WPR_MAX;
    localparam int ADDR_W      = (STORE_WORDS > 1) ? $clog2(STORE_WORDS) : 1;
    localparam int COL_W       = (MAX_WIDTH > 256) ? CFG_W : CFG_W - 1;

    localparam int WCAP_I = (MAX_WIDTH  < rbd_pkg::CFG_MAX) ? MAX_WIDTH  : rbd_pkg::CFG_MAX;
    localparam int HCAP_I = (MAX_HEIGHT < rbd_pkg::CFG_MAX) ? MAX_HEIGHT : rbd_pkg::CFG_MAX;
    localparam logic [CFG_W-1:0]  WIDTH_CAP  = CFG_W'(WCAP_I);
    localparam logic [CFG_W-1:0]  HEIGHT_CAP = CFG_W'(HCAP_I);
    localparam logic [ADDR_W-1:0] LAST_ADDR  = ADDR_W'(STORE_WORDS - 1);

    typedef enum logic [6:0] {
        ST_IDLE      = 7'b0000001,
        ST_FILL      = 7'b0000010,
        ST_RUN_SEG   = 7'b0000100,
        ST_RUN_WR    = 7'b0001000,
        ST_READ      = 7'b0010000,
        ST_READ_DATA = 7'b0100000,
        ST_DONE      = 7'b1000000
    } state_t;

    state_t             state_reg, state_next;
    logic [CFG_W-1:0]   width_reg, width_next;
    logic [CFG_W-1:0]   height_reg, height_next;
    logic [COL_W-1:0]   col_reg, col_next;
    logic [CFG_W-1:0]   row_reg, row_next;
    logic               out_valid_reg, out_valid_next;

    logic               color_reg, color_next;
    logic [CNT_W-1:0]   rem_reg, rem_next;
    logic [COORD_W-1:0] rx_reg, rx_next;
    logic [COORD_W-1:0] ry_reg, ry_next;
    logic [SEG_W-1:0]   n_reg, n_next;
    logic [WORD_BITS-1:0] mask_reg, mask_next;
    logic [ADDR_W-1:0]  seg_addr_reg, seg_addr_next;
    logic [ADDR_W-1:0]  fill_addr_reg, fill_addr_next;
    logic               pix_reg, pix_next;
    logic               oor_reg, oor_next;
    logic               opix_reg, opix_next;
    logic               ooor_reg, ooor_next;
    logic [COORD_W-1:0] ocol_reg, ocol_next;
    logic [CFG_W-1:0]   orow_reg, orow_next;

    logic [CFG_W-1:0]   eff_w;
    logic [CFG_W-1:0]   eff_h;
    logic [CFG_W:0]     wsum;
    logic [WPR_W-1:0]   wpr;

    logic [CFG_W-1:0]   col_ext;
    logic               wrap_pre;
    logic [COL_W-1:0]   cur_col;
    logic [CFG_W-1:0]   cur_col_ext;
    logic [CFG_W-1:0]   cur_row;
    logic [BIT_W-1:0]   lo;
    logic [SEG_W-1:0]   to_word;
    logic [CFG_W-1:0]   to_row;
    logic [CFG_W-1:0]   n_wide;
    logic [SEG_W-1:0]   seg_n;
    logic [SEG_W-1:0]   hi;
    logic [WORD_BITS-1:0] seg_mask;

    logic [CFG_W-1:0]   addr_row;
    logic [CFG_W-1:0]   addr_col;
    logic [LINE_W-1:0]  line_addr;

    logic [CFG_W:0]     col_sum;
    logic               wrap_post;
    logic               out_free;

    logic               ram_we;
    logic [ADDR_W-1:0]  ram_addr;
    logic [WORD_BITS-1:0] ram_wdata;
    logic [WORD_BITS-1:0] ram_rdata;

    // effective geometry
    always_comb
    begin
        if (width_reg == '0)
        begin
            eff_w = CFG_W'(1);
        end
        else if (width_reg > WIDTH_CAP)
        begin
            eff_w = WIDTH_CAP;
        end
        else
        begin
            eff_w = width_reg;
        end

        if (height_reg == '0)
        begin
            eff_h = CFG_W'(1);
        end
        else if (height_reg > HEIGHT_CAP)
        begin
            eff_h = HEIGHT_CAP;
        end
        else
        begin
            eff_h = height_reg;
        end
    end

    assign wsum = {1'b0, eff_w} + (CFG_W + 1)'(WORD_BITS - 1);
    assign wpr  = wsum[CFG_W:BIT_W];

    // run segment: pixels that fit in one word and one row
    assign col_ext     = CFG_W'(col_reg);
    assign wrap_pre    = (col_ext >= eff_w) && (row_reg < eff_h);
    assign cur_col     = wrap_pre ? '0 : col_reg;
    assign cur_row     = wrap_pre ? row_reg + CFG_W'(1) : row_reg;
    assign cur_col_ext = CFG_W'(cur_col);
    assign lo          = cur_col[BIT_W-1:0];
    assign to_word     = SEG_W'(WORD_BITS) - {1'b0, lo};
    assign to_row      = eff_w - cur_col_ext;

    always_comb
    begin
        n_wide = CFG_W'(rem_reg);
        if (CFG_W'(to_word) < n_wide)
        begin
            n_wide = CFG_W'(to_word);
        end
        if (to_row < n_wide)
        begin
            n_wide = to_row;
        end
    end

    assign seg_n = SEG_W'(n_wide);
    assign hi    = {1'b0, lo} + seg_n;

    always_comb
    begin
        for (int i = 0; i < WORD_BITS; i++)
        begin
            seg_mask[i] = (SEG_W'(i) >= {1'b0, lo}) && (SEG_W'(i) < hi);
        end
    end

    // shared word address unit
    assign addr_row  = (state_reg == ST_READ) ? CFG_W'(ry_reg) : cur_row;
    assign addr_col  = (state_reg == ST_READ) ? CFG_W'(rx_reg) : cur_col_ext;
    assign line_addr = LINE_W'(addr_row) * LINE_W'(wpr)
                     + LINE_W'(addr_col[CFG_W-1:BIT_W]);

    assign col_sum   = (CFG_W + 1)'(col_reg) + (CFG_W + 1)'(n_reg);
    assign wrap_post = col_sum >= {1'b0, eff_w};
    assign out_free  = !out_valid_reg || !out_stall;

    // store port
    always_comb
    begin
        ram_we    = (state_reg == ST_FILL) || (state_reg == ST_RUN_WR);
        ram_addr  = ADDR_W'(line_addr);
        ram_wdata = {WORD_BITS{color_reg}};
        if (state_reg == ST_FILL)
        begin
            ram_addr = fill_addr_reg;
        end
        else if (state_reg == ST_RUN_WR)
        begin
            ram_addr  = seg_addr_reg;
            ram_wdata = color_reg ? (ram_rdata | mask_reg) : (ram_rdata & ~mask_reg);
        end
    end

    rbd_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (STORE_WORDS)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        width_next     = width_reg;
        height_next    = height_reg;
        col_next       = col_reg;
        row_next       = row_reg;
        out_valid_next = out_valid_reg;
        color_next     = color_reg;
        rem_next       = rem_reg;
        rx_next        = rx_reg;
        ry_next        = ry_reg;
        n_next         = n_reg;
        mask_next      = mask_reg;
        seg_addr_next  = seg_addr_reg;
        fill_addr_next = fill_addr_reg;
        pix_next       = pix_reg;
        oor_next       = oor_reg;
        opix_next      = opix_reg;
        ooor_next      = ooor_reg;
        ocol_next      = ocol_reg;
        orow_next      = orow_reg;

        if (cfg_we)
        begin
            if (cfg_index == rbd_pkg::CFG_IDX_WIDTH)
            begin
                width_next = cfg_data;
            end
            else
            begin
                height_next = cfg_data;
            end
        end

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    pix_next = 1'b0;
                    oor_next = 1'b0;
                    unique case (op)
                        rbd_pkg::OP_FILL:
                        begin
                            color_next     = fill_color;
                            fill_addr_next = '0;
                            state_next     = ST_FILL;
                        end
                        rbd_pkg::OP_RUN:
                        begin
                            color_next = run_byte[CNT_W];
                            rem_next   = run_byte[CNT_W-1:0];
                            state_next = ST_RUN_SEG;
                        end
                        rbd_pkg::OP_READ:
                        begin
                            rx_next    = read_x;
                            ry_next    = read_y;
                            state_next = ST_READ;
                        end
                        default:
                        begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end
            ST_FILL:
            begin
                fill_addr_next = fill_addr_reg + ADDR_W'(1);
                if (fill_addr_reg == LAST_ADDR)
                begin
                    col_next   = '0;
                    row_next   = '0;
                    state_next = ST_DONE;
                end
            end
            ST_RUN_SEG:
            begin
                if (rem_reg == '0)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    col_next = cur_col;
                    row_next = cur_row;
                    if (cur_row >= eff_h)
                    begin
                        oor_next   = 1'b1;
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        n_next        = seg_n;
                        mask_next     = seg_mask;
                        seg_addr_next = ADDR_W'(line_addr);
                        state_next    = ST_RUN_WR;
                    end
                end
            end
            ST_RUN_WR:
            begin
                rem_next = rem_reg - CNT_W'(n_reg);
                if (wrap_post)
                begin
                    col_next = '0;
                    row_next = row_reg + CFG_W'(1);
                end
                else
                begin
                    col_next = COL_W'(col_sum);
                end
                state_next = ST_RUN_SEG;
            end
            ST_READ:
            begin
                if ((CFG_W'(rx_reg) >= eff_w) || (CFG_W'(ry_reg) >= eff_h))
                begin
                    oor_next   = 1'b1;
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_READ_DATA;
                end
            end
            ST_READ_DATA:
            begin
                pix_next   = ram_rdata[rx_reg[BIT_W-1:0]];
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    opix_next      = pix_reg;
                    ooor_next      = oor_reg;
                    ocol_next      = col_reg[COORD_W-1:0];
                    orow_next      = row_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            width_reg     <= rbd_pkg::DIM_RESET;
            height_reg    <= rbd_pkg::DIM_RESET;
            col_reg       <= '0;
            row_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            width_reg     <= width_next;
            height_reg    <= height_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        color_reg     <= color_next;
        rem_reg       <= rem_next;
        rx_reg        <= rx_next;
        ry_reg        <= ry_next;
        n_reg         <= n_next;
        mask_reg      <= mask_next;
        seg_addr_reg  <= seg_addr_next;
        fill_addr_reg <= fill_addr_next;
        pix_reg       <= pix_next;
        oor_reg       <= oor_next;
        opix_reg      <= opix_next;
        ooor_reg      <= ooor_next;
        ocol_reg      <= ocol_next;
        orow_reg      <= orow_next;
    end

    assign in_stall     = (state_reg != ST_IDLE);
    assign out_valid    = out_valid_reg;
    assign pixel_color  = opix_reg;
    assign out_of_range = ooor_reg;
    assign cursor_col   = ocol_reg;
    assign cursor_row   = orow_reg;

`ifndef SYNTHESIS
    a_seg_sane: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN_WR) |->
            (n_reg != '0) && (n_reg <= SEG_W'(WORD_BITS)) && (mask_reg != '0))
        else $error("run segment empty or wider than a word");

    a_rem_drops: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN_WR) |=> (rem_reg < $past(rem_reg)))
        else $error("run count did not shrink after a word write");

    a_col_in_row: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_RUN_WR) && !cfg_we) |=> (col_ext < eff_w))
        else $error("cursor column left the row after a word write");

    a_fill_home: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_FILL) && (fill_addr_reg == LAST_ADDR)) |=>
            ((col_reg == '0) && (row_reg == '0) && (state_reg == ST_DONE)))
        else $error("fill finished without homing the cursor");
`endif

endmodule

`default_nettype wire

// ===== bench/tb.sv =====
`default_nettype none

module tb;

    localparam int WORD_BITS = rbd_pkg::WORD_BITS;
    localparam int COORD_W   = rbd_pkg::COORD_W;
    localparam int CFG_W     = rbd_pkg::CFG_W;
    localparam int CFG_IDX_W = rbd_pkg::CFG_IDX_W;
    localparam int STORE_DEPTH = rbd_pkg::MAX_HEIGHT_DEF
                               * ((rbd_pkg::MAX_WIDTH_DEF + WORD_BITS - 1) / WORD_BITS);
    localparam logic [1:0] OP_SPARE = 2'd3;
    localparam int HOLD_CYCLES = 400;

    typedef struct packed {
        logic [1:0]         op;
        logic               fill_color;
        logic [7:0]         run_byte;
        logic [COORD_W-1:0] read_x;
        logic [COORD_W-1:0] read_y;
    } beat_t;

    typedef struct packed {
        logic               pixel_color;
        logic               out_of_range;
        logic [COORD_W-1:0] cursor_col;
        logic [CFG_W-1:0]   cursor_row;
    } pixel_result_t;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0] cfg_data;
    logic in_valid;
    logic in_stall;
    logic [1:0] op;
    logic fill_color;
    logic [7:0] run_byte;
    logic [COORD_W-1:0] read_x;
    logic [COORD_W-1:0] read_y;
    logic out_valid;
    logic out_stall;
    logic pixel_color;
    logic out_of_range;
    logic [COORD_W-1:0] cursor_col;
    logic [CFG_W-1:0] cursor_row;

    rle_bitmap_decoder_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .op           (op),
        .fill_color   (fill_color),
        .run_byte     (run_byte),
        .read_x       (read_x),
        .read_y       (read_y),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .pixel_color  (pixel_color),
        .out_of_range (out_of_range),
        .cursor_col   (cursor_col),
        .cursor_row   (cursor_row)
    );

    always #6 clk = ~clk;

    // frame shadow
    logic [WORD_BITS-1:0] frame_words [0:STORE_DEPTH-1];
    int unsigned pen_col;
    int unsigned pen_row;
    logic [CFG_W-1:0] width_reg;
    logic [CFG_W-1:0] height_reg;

    beat_t beat_queue [$];
    pixel_result_t expected_pixels [$];
    beat_t next_beat;
    bit beat_taken = 1'b0;
    bit calm = 1'b0;
    bit hold_request = 1'b0;
    int unsigned hold_left = 0;
    int unsigned send_gap = 0;
    int unsigned recv_gap = 0;

    int errors = 0;
    int results_checked = 0;
    int fills_seen = 0;
    int runs_seen = 0;
    int reads_seen = 0;
    int spare_seen = 0;
    int flagged_seen = 0;

    function automatic int unsigned eff_dim(input logic [CFG_W-1:0] v, input int unsigned lim);
        if (v == 0)
            return 1;
        if (v > lim)
            return lim;
        return v;
    endfunction

    function automatic int unsigned word_at(input int unsigned x, input int unsigned y);
        int unsigned wpr;
        int unsigned idx;
        wpr = (eff_dim(width_reg, rbd_pkg::MAX_WIDTH_DEF) + WORD_BITS - 1) / WORD_BITS;
        idx = y * wpr + x / WORD_BITS;
        return (idx < STORE_DEPTH) ? idx : 0;
    endfunction

    function automatic pixel_result_t decode_beat(input beat_t b);
        pixel_result_t r;
        int unsigned w;
        int unsigned h;
        int unsigned cnt;
        logic shade;
        r = '0;
        w = eff_dim(width_reg, rbd_pkg::MAX_WIDTH_DEF);
        h = eff_dim(height_reg, rbd_pkg::MAX_HEIGHT_DEF);
        case (b.op)
            rbd_pkg::OP_FILL:
            begin
                for (int i = 0; i < STORE_DEPTH; i++)
                    frame_words[i] = {WORD_BITS{b.fill_color}};
                pen_col = 0;
                pen_row = 0;
            end
            rbd_pkg::OP_RUN:
            begin
                cnt = b.run_byte[6:0];
                shade = b.run_byte[7];
                repeat (cnt)
                begin
                    if (pen_col >= w && pen_row < h)
                    begin
                        pen_col = 0;
                        pen_row++;
                    end
                    if (pen_row >= h)
                        r.out_of_range = 1'b1;
                    else
                    begin
                        frame_words[word_at(pen_col, pen_row)][pen_col % WORD_BITS] = shade;
                        pen_col++;
                        if (pen_col >= w)
                        begin
                            pen_col = 0;
                            pen_row++;
                        end
                    end
                end
            end
            rbd_pkg::OP_READ:
            begin
                if (b.read_x >= w || b.read_y >= h)
                    r.out_of_range = 1'b1;
                else
                    r.pixel_color = frame_words[word_at(b.read_x, b.read_y)][b.read_x % WORD_BITS];
            end
            default:
            begin
            end
        endcase
        r.cursor_col = pen_col[COORD_W-1:0];
        r.cursor_row = pen_row[CFG_W-1:0];
        return r;
    endfunction

    function automatic int unsigned gap_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    function automatic logic [CFG_W-1:0] pick_dim();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 8)
            return '0;
        if (r < 16)
            return CFG_W'(rbd_pkg::CFG_MAX);
        if (r < 26)
            return CFG_W'(256);
        if (r < 34)
            return CFG_W'(1);
        if (r < 70)
            return CFG_W'($urandom_range(2, 40));
        return CFG_W'($urandom_range(41, 300));
    endfunction

    function automatic beat_t mk(input logic [1:0] o, input logic fc, input logic [7:0] rb,
                                 input logic [7:0] x, input logic [7:0] y);
        beat_t b;
        b.op = o;
        b.fill_color = fc;
        b.run_byte = rb;
        b.read_x = x;
        b.read_y = y;
        return b;
    endfunction

    function automatic beat_t random_beat();
        beat_t b;
        int unsigned r;
        int unsigned w;
        int unsigned h;
        w = eff_dim(width_reg, rbd_pkg::MAX_WIDTH_DEF);
        h = eff_dim(height_reg, rbd_pkg::MAX_HEIGHT_DEF);
        b = mk(2'($urandom), 1'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
        r = $urandom_range(0, 99);
        if (r < 3)
            b.op = rbd_pkg::OP_FILL;
        else if (r < 55)
        begin
            b.op = rbd_pkg::OP_RUN;
            r = $urandom_range(0, 99);
            if (r < 5)
                b.run_byte[6:0] = '0;
            else if (r < 70)
                b.run_byte[6:0] = 7'($urandom_range(1, 24));
            else if (r < 90)
                b.run_byte[6:0] = 7'($urandom_range(25, 80));
            else
                b.run_byte[6:0] = 7'($urandom_range(81, 127));
        end
        else if (r < 95)
        begin
            b.op = rbd_pkg::OP_READ;
            if ($urandom_range(0, 99) < 80)
            begin
                b.read_x = COORD_W'($urandom_range(0, w - 1));
                b.read_y = COORD_W'($urandom_range(0, h - 1));
            end
        end
        else
            b.op = OP_SPARE;
        return b;
    endfunction

    task automatic report_mismatch(input string what);
        errors++;
        $display("[%0t] mismatch: %s", $time, what);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        if (idx == rbd_pkg::CFG_IDX_WIDTH)
            width_reg = val;
        else
            height_reg = val;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic wait_idle();
        do
        begin
            @(posedge clk);
            #1;
        end
        while (beat_queue.size() != 0 || in_valid || expected_pixels.size() != 0);
    endtask

    task automatic set_dims(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
        wait_idle();
        write_reg(rbd_pkg::CFG_IDX_WIDTH, w);
        write_reg(rbd_pkg::CFG_IDX_HEIGHT, h);
    endtask

    // sender
    always @(negedge clk)
    begin
        if (rst_n && (!in_valid || beat_taken))
        begin
            if (send_gap > 0)
            begin
                in_valid <= 1'b0;
                send_gap--;
            end
            else if (beat_queue.size() > 0)
            begin
                next_beat = beat_queue.pop_front();
                in_valid <= 1'b1;
                op <= next_beat.op;
                fill_color <= next_beat.fill_color;
                run_byte <= next_beat.run_byte;
                read_x <= next_beat.read_x;
                read_y <= next_beat.read_y;
                send_gap = calm ? 0 : gap_len();
            end
            else
                in_valid <= 1'b0;
        end
    end

    // receiver
    always @(negedge clk)
    begin
        if (hold_request)
        begin
            hold_left = HOLD_CYCLES;
            hold_request = 1'b0;
        end
        if (!rst_n)
            out_stall <= 1'b0;
        else if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left--;
        end
        else if (recv_gap > 0)
        begin
            out_stall <= 1'b1;
            recv_gap--;
        end
        else
        begin
            out_stall <= 1'b0;
            recv_gap = calm ? 0 : gap_len();
        end
    end

    // checker and predictor
    always @(posedge clk)
    begin
        pixel_result_t want;
        beat_t got_beat;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                results_checked++;
                if (out_of_range === 1'b1)
                    flagged_seen++;
                if (expected_pixels.size() == 0)
                    report_mismatch("result beat with nothing expected");
                else
                begin
                    want = expected_pixels.pop_front();
                    if (pixel_color !== want.pixel_color)
                        report_mismatch($sformatf("pixel_color got %b want %b",
                                                  pixel_color, want.pixel_color));
                    if (out_of_range !== want.out_of_range)
                        report_mismatch($sformatf("out_of_range got %b want %b",
                                                  out_of_range, want.out_of_range));
                    if (cursor_col !== want.cursor_col)
                        report_mismatch($sformatf("cursor_col got %0d want %0d",
                                                  cursor_col, want.cursor_col));
                    if (cursor_row !== want.cursor_row)
                        report_mismatch($sformatf("cursor_row got %0d want %0d",
                                                  cursor_row, want.cursor_row));
                end
            end
            beat_taken = in_valid && !in_stall;
            if (beat_taken)
            begin
                got_beat = {op, fill_color, run_byte, read_x, read_y};
                case (got_beat.op)
                    rbd_pkg::OP_FILL: fills_seen++;
                    rbd_pkg::OP_RUN: runs_seen++;
                    rbd_pkg::OP_READ: reads_seen++;
                    default: spare_seen++;
                endcase
                expected_pixels.push_back(decode_beat(got_beat));
            end
        end
    end

    initial
    begin
        #(12 * 4000000);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        op = rbd_pkg::OP_FILL;
        fill_color = 1'b0;
        run_byte = '0;
        read_x = '0;
        read_y = '0;
        out_stall = 1'b0;
        width_reg = rbd_pkg::DIM_RESET;
        height_reg = rbd_pkg::DIM_RESET;
        pen_col = 0;
        pen_row = 0;
        for (int i = 0; i < STORE_DEPTH; i++)
            frame_words[i] = '0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // default frame: fill, long runs, zero runs, row wrap, corner reads
        beat_queue.push_back(mk(rbd_pkg::OP_FILL, 1'b0, 8'h00, 8'h00, 8'h00));
        beat_queue.push_back(mk(rbd_pkg::OP_READ, 1'b0, 8'h00, 8'h00, 8'h00));
        beat_queue.push_back(mk(rbd_pkg::OP_RUN, 1'b0, 8'hFF, 8'h00, 8'h00));
        beat_queue.push_back(mk(rbd_pkg::OP_RUN, 1'b0, 8'h00, 8'h00, 8'h00));
        beat_queue.push_back(mk(rbd_pkg::OP_RUN, 1'b0, 8'h80, 8'h00, 8'h00));
        beat_queue.push_back(mk(rbd_pkg::OP_RUN, 1'b0, 8'h7F, 8'h00, 8'h00));
        beat_queue.push_back(mk(rbd_pkg::OP_RUN, 1'b0, 8'h83, 8'h00, 8'h00));
        beat_queue.push_back(mk(rbd_pkg::OP_RUN, 1'b0, 8'h27, 8'h00, 8'h00));
        beat_queue.push_back(mk(rbd_pkg::OP_READ, 1'b0, 8'h00, 8'hFF, 8'h00));
        beat_queue.push_back(mk(rbd_pkg::OP_READ, 1'b0, 8'h00, 8'd126, 8'h00));
        beat_queue.push_back(mk(rbd_pkg::OP_READ, 1'b0, 8'h00, 8'd127, 8'h00));
        beat_queue.push_back(mk(rbd_pkg::OP_READ, 1'b0, 8'h00, 8'hFF, 8'hFF));
        beat_queue.push_back(mk(OP_SPARE, 1'b1, 8'hFF, 8'hFF, 8'hFF));

        // shrunk frame: cursor past the width, frame fills up and drops pixels
        set_dims(9'd10, 9'd4);
        beat_queue.push_back(mk(rbd_pkg::OP_RUN, 1'b0, 8'h82, 8'h00, 8'h00));
        beat_queue.push_back(mk(rbd_pkg::OP_RUN, 1'b0, 8'hFF, 8'h00, 8'h00));
        beat_queue.push_back(mk(rbd_pkg::OP_RUN, 1'b0, 8'h81, 8'h00, 8'h00));
        beat_queue.push_back(mk(rbd_pkg::OP_RUN, 1'b0, 8'h00, 8'h00, 8'h00));
        beat_queue.push_back(mk(rbd_pkg::OP_READ, 1'b0, 8'h00, 8'd10, 8'd0));
        beat_queue.push_back(mk(rbd_pkg::OP_READ, 1'b0, 8'h00, 8'd9, 8'd3));
        beat_queue.push_back(mk(rbd_pkg::OP_READ, 1'b0, 8'h00, 8'd0, 8'd4));

        // zero registers act as one pixel
        set_dims(9'd0, 9'd0);
        beat_queue.push_back(mk(rbd_pkg::OP_READ, 1'b0, 8'h00, 8'd1, 8'd0));
        beat_queue.push_back(mk(rbd_pkg::OP_FILL, 1'b1, 8'h00, 8'h00, 8'h00));
        beat_queue.push_back(mk(rbd_pkg::OP_RUN, 1'b0, 8'h05, 8'h00, 8'h00));
        beat_queue.push_back(mk(rbd_pkg::OP_READ, 1'b0, 8'h00, 8'd0, 8'd0));

        // oversized registers clamp to the store size
        set_dims(CFG_W'(rbd_pkg::CFG_MAX), CFG_W'(rbd_pkg::CFG_MAX));
        beat_queue.push_back(mk(rbd_pkg::OP_RUN, 1'b0, 8'hFF, 8'h00, 8'h00));
        beat_queue.push_back(mk(rbd_pkg::OP_READ, 1'b0, 8'h00, 8'd200, 8'd1));

        for (int ph = 0; ph < 8; ph++)
        begin
            set_dims(pick_dim(), pick_dim());
            calm = (ph == 0);
            if (ph == 2)
                hold_request = 1'b1;
            if ($urandom_range(0, 99) < 40)
                beat_queue.push_back(mk(rbd_pkg::OP_FILL, 1'($urandom), 8'($urandom),
                                        8'($urandom), 8'($urandom)));
            repeat (50)
                beat_queue.push_back(random_beat());
        end

        wait_idle();
        repeat (20) @(posedge clk);
        $display("covered %0d fills, %0d runs, %0d reads, %0d unused-op beats",
                 fills_seen, runs_seen, reads_seen, spare_seen);
        $display("checked %0d result beats, %0d flagged out of range, %0d mismatches",
                 results_checked, flagged_seen, errors);
        if (errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

`default_nettype wire
